>>> rtl/dcm_pkg.sv
// Package: shared types, constants and helpers for the dictionary coverage matcher.
package dcm_pkg;

  localparam int TRIE_AW   = 16;
  localparam int TRIE_WORDS = 1 << TRIE_AW;
  localparam int RING_AW   = 6;
  localparam int MAX_DEPTH = 1 << RING_AW;
  localparam int FILL_W    = RING_AW + 1;
  localparam int QUEUE_AW  = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_BYTE,
    OP_END
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [TRIE_AW-1:0] addr;
    logic [31:0]        word;
    logic [7:0]         symbol;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR0,
    ST_HDR1,
    ST_HDR2,
    ST_SCAN,
    ST_CMP,
    ST_LEN,
    ST_PUSH,
    ST_SHRD,
    ST_SHEX,
    ST_PUW,
    ST_PURD,
    ST_PUCMP,
    ST_RWD,
    ST_DROP,
    ST_DONE
  } state_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == 32'hffff_ffff) ? c : c + 32'd1;
  endfunction

  function automatic logic [31:0] dec_floor(input logic [31:0] c);
    dec_floor = (c == 32'd0) ? c : c - 32'd1;
  endfunction

endpackage

>>> rtl/dcm_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
module dcm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_kind,
  input  logic [15:0]         in_load_address,
  input  logic [31:0]         in_load_word,
  input  logic [7:0]          in_symbol,
  output logic                q_valid,
  output dcm_pkg::item_t      q_item,
  input  logic                q_pop
);
  import dcm_pkg::*;

  item_t                 q_mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]     count_r, count_nxt;
  logic                  take;
  logic                  keep;
  item_t                 cls;

  assign in_full = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign take    = in_push && !in_full;

  // Classify; the unused kind code is taken and dropped.
  always_comb begin
    cls.addr   = in_load_address;
    cls.word   = in_load_word;
    cls.symbol = in_symbol;
    keep       = 1'b1;
    case (in_kind)
      KIND_LOAD: cls.op = OP_LOAD;
      KIND_BYTE: cls.op = OP_BYTE;
      KIND_END:  cls.op = OP_END;
      default: begin
        cls.op = OP_LOAD;
        keep   = 1'b0;
      end
    endcase
  end

  assign q_valid = (count_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (take && keep) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (q_pop && q_valid) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + (QUEUE_AW+1)'(take && keep) - (QUEUE_AW+1)'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && keep) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n)
      count_r <= (QUEUE_AW+1)'(QUEUE_DEPTH);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue count overflow");

  property p_push_counts;
    @(posedge clk) disable iff (!rst_n)
      (take && keep && !(q_pop && q_valid)) |=> (count_r == $past(count_r) + 1'b1);
  endproperty
  a_push_counts: assert property (p_push_counts) else $error("queue count not advanced");

  property p_pop_counts;
    @(posedge clk) disable iff (!rst_n)
      (!(take && keep) && q_pop && q_valid) |=> (count_r == $past(count_r) - 1'b1);
  endproperty
  a_pop_counts: assert property (p_pop_counts) else $error("queue count not reduced");

endmodule

>>> rtl/dcm_back.sv
// Back end: trie memory, automaton walk, context ring, counters and result register.
module dcm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  dcm_pkg::item_t      q_item,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [31:0]         out_uncovered_chars,
  output logic [31:0]         out_uncovered_links,
  output logic [31:0]         out_absent_chars
);
  import dcm_pkg::*;

  state_t state_r, state_nxt;

  logic [31:0]        trie_mem [TRIE_WORDS];
  logic               t_we;
  logic [TRIE_AW-1:0] t_wa, t_ra;
  logic [31:0]        t_wd, t_rd_r;

  logic [FILL_W-1:0]  ring_mem [MAX_DEPTH];
  logic               r_we;
  logic [RING_AW-1:0] r_wa, r_ra1, r_ra2;
  logic [FILL_W-1:0]  r_wd, r_rd1_r, r_rd2_r;

  logic [TRIE_AW-1:0] node_r, node_nxt;
  logic [14:0]        depth_r, depth_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic [TRIE_AW-1:0] rew_r, rew_nxt;
  logic               rew_ok_r, rew_ok_nxt;
  logic [7:0]         idx_r, idx_nxt;
  logic [FILL_W-1:0]  steps_r, steps_nxt;
  logic [14:0]        drop_r, drop_nxt;
  logic [15:0]        len_r, len_nxt;
  logic               is_end_r, is_end_nxt;
  logic [7:0]         sym_r, sym_nxt;
  logic               shed_push_r, shed_push_nxt;
  logic [RING_AW-1:0] head_r, head_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [31:0]        unc_r, unc_nxt;
  logic [31:0]        unl_r, unl_nxt;
  logic [31:0]        abs_r, abs_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        res_c_r, res_l_r, res_a_r;
  logic               res_load;

  logic               scan_child;
  logic               can_rewind;
  logic               child_hit;
  logic               len_fits;
  logic [RING_AW-1:0] at_idx;
  logic [FILL_W-1:0]  shed_v;
  logic [14:0]        rdepth;

  assign scan_child = !is_end_r && (idx_r < cnt_r);
  assign can_rewind = rew_ok_r && (steps_r < FILL_W'(MAX_DEPTH));
  assign child_hit  = (t_rd_r[31:24] == sym_r);
  assign len_fits   = (len_r != '0) && (len_r <= 16'(fill_r) + 16'd1);
  assign at_idx     = head_r + fill_r[RING_AW-1:0] - len_r[RING_AW-1:0];
  assign shed_v     = r_rd1_r;
  assign rdepth     = t_rd_r[30:16];
  assign res_load   = (state_r == ST_DONE) && (!out_valid_r || out_pop);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && q_item.op != OP_LOAD) state_nxt = ST_HDR0;
      end
      ST_HDR0: state_nxt = ST_HDR1;
      ST_HDR1: state_nxt = ST_HDR2;
      ST_HDR2: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_child)      state_nxt = ST_CMP;
        else if (can_rewind) state_nxt = ST_RWD;
        else if (is_end_r)   state_nxt = ST_DONE;
        else                 state_nxt = ST_IDLE;
      end
      ST_CMP:  state_nxt = child_hit ? ST_LEN : ST_SCAN;
      ST_LEN:  state_nxt = ST_PUSH;
      ST_PUSH: state_nxt = (fill_r == FILL_W'(MAX_DEPTH)) ? ST_SHRD : ST_PUW;
      ST_SHRD: state_nxt = ST_SHEX;
      ST_SHEX: state_nxt = shed_push_r ? ST_PUW : ST_DROP;
      ST_DROP: begin
        if (drop_r != '0 && fill_r != '0) state_nxt = ST_SHRD;
        else                              state_nxt = ST_HDR0;
      end
      ST_RWD:  state_nxt = ST_DROP;
      ST_PUW:  state_nxt = len_fits ? ST_PURD : ST_IDLE;
      ST_PURD: state_nxt = ST_PUCMP;
      ST_PUCMP: state_nxt = ST_IDLE;
      ST_DONE: begin
        if (res_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    node_nxt      = node_r;
    depth_nxt     = depth_r;
    cnt_nxt       = cnt_r;
    rew_nxt       = rew_r;
    rew_ok_nxt    = rew_ok_r;
    idx_nxt       = idx_r;
    steps_nxt     = steps_r;
    drop_nxt      = drop_r;
    len_nxt       = len_r;
    is_end_nxt    = is_end_r;
    sym_nxt       = sym_r;
    shed_push_nxt = shed_push_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    unc_nxt       = unc_r;
    unl_nxt       = unl_r;
    abs_nxt       = abs_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    t_we          = 1'b0;
    t_wa          = q_item.addr;
    t_wd          = q_item.word;
    t_ra          = node_r;
    r_we          = 1'b0;
    r_wa          = head_r + 1'b1;
    r_wd          = '0;
    r_ra1         = head_r;
    r_ra2         = head_r + 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == OP_LOAD) begin
            t_we = 1'b1;
          end else begin
            is_end_nxt = (q_item.op == OP_END);
            sym_nxt    = q_item.symbol;
            steps_nxt  = '0;
          end
        end
      end
      ST_HDR1: begin
        t_ra      = node_r + 1'b1;
        depth_nxt = t_rd_r[30:16];
      end
      ST_HDR2: begin
        cnt_nxt    = t_rd_r[7:0];
        rew_nxt    = t_rd_r[23:8];
        rew_ok_nxt = (t_rd_r[31:24] == 8'd0);
        idx_nxt    = '0;
      end
      ST_SCAN: begin
        if (scan_child) begin
          t_ra = node_r + TRIE_AW'(2) + TRIE_AW'(idx_r);
        end else if (can_rewind) begin
          t_ra = rew_r;
        end else begin
          abs_nxt = sat_inc(abs_r);
          unc_nxt = sat_inc(unc_r);
          if (rew_ok_r) node_nxt = '0;
        end
      end
      ST_CMP: begin
        if (child_hit) node_nxt = t_rd_r[TRIE_AW-1:0];
        else           idx_nxt  = idx_r + 1'b1;
      end
      ST_PUSH: begin
        len_nxt       = t_rd_r[15:0];
        shed_push_nxt = (fill_r == FILL_W'(MAX_DEPTH));
      end
      ST_SHEX: begin
        // Retire the oldest context entry; hand longer reach to its successor.
        if (shed_v == '0) begin
          unc_nxt = sat_inc(unc_r);
          unl_nxt = sat_inc(unl_r);
        end else if (shed_v == FILL_W'(1)) begin
          unl_nxt = sat_inc(unl_r);
        end else if (fill_r >= FILL_W'(2) && (shed_v - 1'b1) > r_rd2_r) begin
          r_we = 1'b1;
          r_wd = shed_v - 1'b1;
        end
        head_nxt = head_r + 1'b1;
        fill_nxt = fill_r - 1'b1;
        if (shed_push_r) shed_push_nxt = 1'b0;
        else             drop_nxt      = drop_r - 1'b1;
      end
      ST_DROP: begin
        if (!(drop_r != '0 && fill_r != '0)) steps_nxt = steps_r + 1'b1;
      end
      ST_RWD: begin
        drop_nxt = (depth_r > rdepth) ? depth_r - rdepth : '0;
        node_nxt = rew_r;
      end
      ST_PUW: begin
        r_we     = 1'b1;
        r_wa     = head_r + fill_r[RING_AW-1:0];
        r_wd     = '0;
        fill_nxt = fill_r + 1'b1;
      end
      ST_PURD: begin
        r_ra1 = at_idx;
      end
      ST_PUCMP: begin
        r_wa = at_idx;
        r_wd = len_r[FILL_W-1:0];
        if (len_r > 16'(r_rd1_r)) r_we = 1'b1;
      end
      ST_DONE: begin
        if (res_load) begin
          out_valid_nxt = 1'b1;
          node_nxt      = '0;
          head_nxt      = '0;
          fill_nxt      = '0;
          unc_nxt       = '0;
          unl_nxt       = '0;
          abs_nxt       = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      node_r      <= '0;
      head_r      <= '0;
      fill_r      <= '0;
      unc_r       <= '0;
      unl_r       <= '0;
      abs_r       <= '0;
      out_valid_r <= 1'b0;
      shed_push_r <= 1'b0;
      steps_r     <= '0;
      is_end_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      node_r      <= node_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      unc_r       <= unc_nxt;
      unl_r       <= unl_nxt;
      abs_r       <= abs_nxt;
      out_valid_r <= out_valid_nxt;
      shed_push_r <= shed_push_nxt;
      steps_r     <= steps_nxt;
      is_end_r    <= is_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    depth_r  <= depth_nxt;
    cnt_r    <= cnt_nxt;
    rew_r    <= rew_nxt;
    rew_ok_r <= rew_ok_nxt;
    idx_r    <= idx_nxt;
    drop_r   <= drop_nxt;
    len_r    <= len_nxt;
    sym_r    <= sym_nxt;
    if (res_load) begin
      res_c_r <= dec_floor(unc_r);
      res_l_r <= dec_floor(unl_r);
      res_a_r <= dec_floor(abs_r);
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) trie_mem[t_wa] <= t_wd;
    t_rd_r <= trie_mem[t_ra];
  end

  always_ff @(posedge clk) begin
    if (r_we) ring_mem[r_wa] <= r_wd;
    r_rd1_r <= ring_mem[r_ra1];
    r_rd2_r <= ring_mem[r_ra2];
  end

  assign out_empty           = !out_valid_r;
  assign out_uncovered_chars = res_c_r;
  assign out_uncovered_links = res_l_r;
  assign out_absent_chars    = res_a_r;

  property p_fill_bound;
    @(posedge clk) disable iff (!rst_n)
      fill_r <= FILL_W'(MAX_DEPTH);
  endproperty
  a_fill_bound: assert property (p_fill_bound) else $error("ring fill beyond depth");

  property p_pop_idle;
    @(posedge clk) disable iff (!rst_n)
      q_pop |-> (state_r == ST_IDLE);
  endproperty
  a_pop_idle: assert property (p_pop_idle) else $error("item taken while busy");

  property p_result_clears;
    @(posedge clk) disable iff (!rst_n)
      res_load |=> (out_valid_r && fill_r == '0 && unc_r == '0 && node_r == '0);
  endproperty
  a_result_clears: assert property (p_result_clears) else $error("context not cleared");

  property p_result_held;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && !out_pop) |=> (out_valid_r && $stable(res_c_r));
  endproperty
  a_result_held: assert property (p_result_held) else $error("result lost before pop");

endmodule

>>> rtl/dictionary_coverage_matcher.sv
// Top level: dictionary coverage matcher built from a queued front end and a trie walker.
//
//  channel   direction  handshake        fields
//  in_*      input      in_push/in_full  kind, load_address, load_word, symbol
//  out_*     output     out_pop/out_empty uncovered_chars, uncovered_links, absent_chars
//
// A load writes its trie word from the idle state. A text byte reads the node header,
// then examines the children in turn; on a hit it records the match in the context ring,
// shedding the oldest entry if the ring is full, and on a miss it follows a failure link
// and sheds context entries. The walker reads the trie memory one address at a time.
// An end item examines no children but follows failure links like a byte, then waits
// while the result register is still full. Reset is synchronous, active low; the trie memory is not cleared.
// The input queue holds four items, so input accepts go on while the walker is busy.
module dictionary_coverage_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_load_address,
  input  logic [31:0] in_load_word,
  input  logic [7:0]  in_symbol,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_uncovered_chars,
  output logic [31:0] out_uncovered_links,
  output logic [31:0] out_absent_chars
);
  import dcm_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  dcm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_kind         (in_kind),
    .in_load_address (in_load_address),
    .in_load_word    (in_load_word),
    .in_symbol       (in_symbol),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  dcm_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_uncovered_chars (out_uncovered_chars),
    .out_uncovered_links (out_uncovered_links),
    .out_absent_chars    (out_absent_chars)
  );

endmodule
